// ===== rtl/core/brl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

   localparam int COORD_BITS = 6;
   localparam int COLOR_BITS = 8;
   localparam int ERR_BITS   = COORD_BITS + 1;

   localparam int REQ_DATA_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS = RSP_DATA_BITS - RSP_FIELD_BITS;

   // power of two so the pointers wrap on their own
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [COORD_BITS-1:0] CFG_SIZE_RESET = COORD_BITS'(32);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_IMAGE_WIDTH  = CSR_INDEX_BITS'(0),
      REG_IMAGE_HEIGHT = CSR_INDEX_BITS'(1)
   } csr_index_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] image_width;
      logic [COORD_BITS-1:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic                        steep;
      logic signed [COORD_BITS-1:0] cur_major;
      logic signed [COORD_BITS-1:0] cur_minor;
      logic signed [COORD_BITS-1:0] end_major;
      logic signed [ERR_BITS-1:0]   error_term;
      logic [COORD_BITS-1:0]        delta_major;
      logic [COORD_BITS-1:0]        delta_minor;
      logic                        major_dir;
      logic                        minor_dir;
      logic [COLOR_BITS-1:0]        color;
   } seg_type;

endpackage

`default_nettype wire

// ===== rtl/core/bresenham_line_rasterizer_core.sv =====
// a request passes the front register and the queue before the walker register
// takes it, when the walker is idle, and then shows its first pixel on rsp
// throughput: one pixel per cycle while rsp_tready is high, |major delta| + 1 pixels per
// request (1 to 64); the walker step sets this, and the next segment follows with no gap
// reset: synchronous active high, clears the queue and walker, sizes return to 32
`timescale 1ns / 1ps
`default_nettype none

module bresenham_line_rasterizer_core import brl_pkg::*; (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   // x_start, y_start, x_end, y_end, color
   input  wire [REQ_DATA_BITS-1:0]   req_tdata,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   // x, y, pixel_value, zero pad
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // inside_res
   output logic                      rsp_tuser,
   output logic                      rsp_tlast,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire [COORD_BITS-1:0]      csr_data
);

   cfg_type cfg_ff, cfg_in;
   logic    front_valid, front_ready;
   seg_type front_seg;
   logic    queue_valid, queue_ready;
   seg_type queue_seg;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_IMAGE_WIDTH:  cfg_in.image_width  = csr_data;
            REG_IMAGE_HEIGHT: cfg_in.image_height = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= CFG_SIZE_RESET;
         cfg_ff.image_height <= CFG_SIZE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   brl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .seg_valid  (front_valid),
      .seg_ready  (front_ready),
      .seg        (front_seg)
   );

   brl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_seg    (front_seg),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_seg   (queue_seg)
   );

   brl_walk u_walk (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .seg_valid  (queue_valid),
      .seg_ready  (queue_ready),
      .seg        (queue_seg),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== rtl/core/brl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_front import brl_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   input  wire [REQ_DATA_BITS-1:0]  req_tdata,
   output logic                     seg_valid,
   input  wire                      seg_ready,
   output seg_type                  seg
);

   logic signed [COORD_BITS-1:0] xs, ys, xe, ye;
   logic [COLOR_BITS-1:0]        color;
   logic signed [COORD_BITS:0]   dx, dy;
   logic [COORD_BITS-1:0]        adx, ady;
   logic                         steep;
   logic signed [COORD_BITS-1:0] ma0, mi0, ma1, mi1;
   logic [COORD_BITS-1:0]        dmaj;
   logic                         accept;
   seg_type                      seg_ff, seg_in;
   logic                         valid_ff, valid_in;

   always_comb begin
      xs    = req_tdata[COORD_BITS-1:0];
      ys    = req_tdata[2*COORD_BITS-1:COORD_BITS];
      xe    = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
      ye    = req_tdata[4*COORD_BITS-1:3*COORD_BITS];
      color = req_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];

      dx  = (COORD_BITS+1)'(xe) - (COORD_BITS+1)'(xs);
      dy  = (COORD_BITS+1)'(ye) - (COORD_BITS+1)'(ys);
      adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
      ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);

      steep = ady > adx;
      if (steep) begin
         ma0 = ys; mi0 = xs; ma1 = ye; mi1 = xe;
      end else begin
         ma0 = xs; mi0 = ys; ma1 = xe; mi1 = ye;
      end
      dmaj = steep ? ady : adx;

      seg_in.steep       = steep;
      seg_in.cur_major   = ma0;
      seg_in.cur_minor   = mi0;
      seg_in.end_major   = ma1;
      seg_in.delta_major = dmaj;
      seg_in.delta_minor = steep ? adx : ady;
      seg_in.error_term  = $signed({2'b00, dmaj[COORD_BITS-1:1]});
      seg_in.major_dir   = ma0 > ma1;
      seg_in.minor_dir   = !(mi0 < mi1);
      seg_in.color       = color;
   end

   assign req_tready = !valid_ff || seg_ready;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (seg_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seg_ff <= seg_in;
      end
   end

   assign seg_valid = valid_ff;
   assign seg       = seg_ff;

endmodule

`default_nettype wire

// ===== rtl/core/brl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_queue import brl_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  wire     in_valid,
   output logic    in_ready,
   input  seg_type in_seg,
   output logic    out_valid,
   input  wire     out_ready,
   output seg_type out_seg
);

   seg_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      push, pop;

   assign in_ready  = count_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_seg   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_seg;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/brl_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_walk import brl_pkg::*; (
   input  wire                      clock,
   input  wire                      reset,
   input  cfg_type                  cfg,
   input  wire                      seg_valid,
   output logic                     seg_ready,
   input  seg_type                  seg,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);

   seg_type                      cur_ff, cur_in;
   logic                         active_ff, active_in;
   logic signed [COORD_BITS-1:0] px, py;
   logic                         fin, fire;
   logic signed [ERR_BITS-1:0]   err_sub;

   always_comb begin
      px  = cur_ff.steep ? cur_ff.cur_minor : cur_ff.cur_major;
      py  = cur_ff.steep ? cur_ff.cur_major : cur_ff.cur_minor;
      fin = cur_ff.cur_major == cur_ff.end_major;
   end

   assign fire      = active_ff && rsp_tready;
   assign seg_ready = !active_ff || (fire && fin);

   always_comb begin
      err_sub   = cur_ff.error_term - $signed({1'b0, cur_ff.delta_minor});
      cur_in    = cur_ff;
      active_in = active_ff;
      if (seg_ready) begin
         active_in = seg_valid;
         cur_in    = seg;
      end else if (fire) begin
         cur_in.error_term = err_sub;
         if (err_sub < 0) begin
            cur_in.error_term = err_sub + $signed({1'b0, cur_ff.delta_major});
            cur_in.cur_minor  = cur_ff.minor_dir ? cur_ff.cur_minor - 1'b1
                                                 : cur_ff.cur_minor + 1'b1;
         end
         cur_in.cur_major = cur_ff.major_dir ? cur_ff.cur_major - 1'b1
                                             : cur_ff.cur_major + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_tvalid = active_ff;
   assign rsp_tdata  = {{RSP_PAD_BITS{1'b0}}, cur_ff.color, py, px};
   assign rsp_tlast  = fin;
   assign rsp_tuser  = !px[COORD_BITS-1] && !py[COORD_BITS-1] &&
                       (px < $signed({1'b0, cfg.image_width})) &&
                       (py < $signed({1'b0, cfg.image_height}));

endmodule

`default_nettype wire

// ===== rtl/core/brl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module brl_checker import brl_pkg::*; (
   input wire                      clock,
   input wire                      reset,
   input wire                      rsp_tvalid,
   input wire                      rsp_tready,
   input wire [RSP_DATA_BITS-1:0]  rsp_tdata,
   input wire                      rsp_tuser,
   input wire                      rsp_tlast
);

   logic [COORD_BITS-1:0] prev_x_ff, prev_y_ff;
   logic [COORD_BITS-1:0] step_x, step_y;
   logic                  x_ok, y_ok, step_ok;

   always_ff @(posedge clock) begin
      prev_x_ff <= rsp_tdata[COORD_BITS-1:0];
      prev_y_ff <= rsp_tdata[2*COORD_BITS-1:COORD_BITS];
   end

   always_comb begin
      step_x  = rsp_tdata[COORD_BITS-1:0] - prev_x_ff;
      step_y  = rsp_tdata[2*COORD_BITS-1:COORD_BITS] - prev_y_ff;
      x_ok    = (step_x == '0) || (step_x == COORD_BITS'(1)) || (step_x == '1);
      y_ok    = (step_y == '0) || (step_y == COORD_BITS'(1)) || (step_y == '1);
      step_ok = x_ok && y_ok && !((step_x == '0) && (step_y == '0));
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled pixel changed");

   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a segment");

   a_adjacent: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> step_ok)
      else $error("next pixel is not a neighbor");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("pixel shown right after reset");

endmodule

bind bresenham_line_rasterizer_core brl_checker u_brl_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import brl_pkg::*;

   localparam int SETTLE_CYCLES = 6;
   localparam int QUIET_LIMIT = 1000;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_2 = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_3 = CSR_INDEX_BITS'(3);

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0]        color;
      logic                         in_image;
      logic                         last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [COORD_BITS-1:0] csr_data = '0;

   pixel_type line_pixels[$];
   logic [COORD_BITS-1:0] image_width;
   logic [COORD_BITS-1:0] image_height;
   bit stall_free = 1'b0;
   int errors = 0;
   int quiet_cycles = 0;

   bresenham_line_rasterizer_core uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   function automatic int span(int a, int b);
      return (b > a) ? b - a : a - b;
   endfunction

   function automatic int clamp_coord(int v);
      if (v > 31) return 31;
      if (v < -32) return -32;
      return v;
   endfunction

   // walk one segment and queue every pixel it should produce
   function automatic void predict_line(logic [REQ_DATA_BITS-1:0] d);
      int xs, ys, xe, ye;
      int maj, mnr, maj_end, mnr_end, d_maj, d_mnr, err, px, py;
      bit steep, maj_down, mnr_down, done;
      pixel_type p;
      xs = int'($signed(d[COORD_BITS-1:0]));
      ys = int'($signed(d[2*COORD_BITS-1:COORD_BITS]));
      xe = int'($signed(d[3*COORD_BITS-1:2*COORD_BITS]));
      ye = int'($signed(d[4*COORD_BITS-1:3*COORD_BITS]));
      p.color = d[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
      steep = span(ys, ye) > span(xs, xe);
      maj = steep ? ys : xs;
      mnr = steep ? xs : ys;
      maj_end = steep ? ye : xe;
      mnr_end = steep ? xe : ye;
      d_maj = span(maj, maj_end);
      d_mnr = span(mnr, mnr_end);
      err = d_maj / 2;
      mnr_down = !(mnr < mnr_end);
      maj_down = maj > maj_end;
      do begin
         px = steep ? mnr : maj;
         py = steep ? maj : mnr;
         done = (maj == maj_end);
         p.x = px[COORD_BITS-1:0];
         p.y = py[COORD_BITS-1:0];
         p.in_image = px >= 0 && py >= 0 && px < int'(image_width) &&
                      py < int'(image_height);
         p.last = done;
         line_pixels.push_back(p);
         err -= d_mnr;
         if (err < 0) begin
            mnr += mnr_down ? -1 : 1;
            err += d_maj;
         end
         if (!done) maj += maj_down ? -1 : 1;
      end while (!done);
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         image_width = CFG_SIZE_RESET;
         image_height = CFG_SIZE_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_IMAGE_WIDTH) image_width = csr_data;
            else if (csr_index == REG_IMAGE_HEIGHT) image_height = csr_data;
         end
         if (req_tvalid && req_tready) predict_line(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (line_pixels.size() == 0) begin
               $display("%0t unexpected pixel expected none actual x=%0d y=%0d", $time,
                        $signed(rsp_tdata[COORD_BITS-1:0]),
                        $signed(rsp_tdata[2*COORD_BITS-1:COORD_BITS]));
               errors++;
            end else begin
               want = line_pixels.pop_front();
               check_field("x", int'(want.x), int'($signed(rsp_tdata[COORD_BITS-1:0])));
               check_field("y", int'(want.y),
                           int'($signed(rsp_tdata[2*COORD_BITS-1:COORD_BITS])));
               check_field("pixel_value", int'(want.color),
                           int'(rsp_tdata[2*COORD_BITS+COLOR_BITS-1:2*COORD_BITS]));
               check_field("inside_res", int'(want.in_image), int'(rsp_tuser));
               check_field("last", int'(want.last), int'(rsp_tlast));
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_tready <= stall_free || ($urandom_range(99) >= 25);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_segment(input int xs, input int ys, input int xe, input int ye,
                               input int color);
      logic [COORD_BITS-1:0] xs_f, ys_f, xe_f, ye_f;
      logic [COLOR_BITS-1:0] color_f;
      xs_f = COORD_BITS'(xs);
      ys_f = COORD_BITS'(ys);
      xe_f = COORD_BITS'(xe);
      ye_f = COORD_BITS'(ye);
      color_f = COLOR_BITS'(color);
      if (!stall_free) begin
         while ($urandom_range(99) < 25) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {color_f, ye_f, xe_f, ys_f, xs_f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_segment();
      int xs, ys, xe, ye;
      xs = int'($urandom_range(63)) - 32;
      ys = int'($urandom_range(63)) - 32;
      if ($urandom_range(99) < 30) begin
         // short segment
         xe = clamp_coord(xs + int'($urandom_range(8)) - 4);
         ye = clamp_coord(ys + int'($urandom_range(8)) - 4);
      end else begin
         xe = int'($urandom_range(63)) - 32;
         ye = int'($urandom_range(63)) - 32;
      end
      send_segment(xs, ys, xe, ye, int'($urandom_range(255)));
   endtask

   task automatic drain_lines();
      req_tvalid <= 1'b0;
      // let the last accepted request reach the expected queue
      @(posedge clock);
      while (line_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index, input int value);
      drain_lines();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= COORD_BITS'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_single_points();
      send_segment(0, 0, 0, 0, 0);
      send_segment(-32, -32, -32, -32, 255);
      send_segment(31, 31, 31, 31, 8'hA5);
   endtask

   task automatic test_axis_lines();
      send_segment(-32, 5, 31, 5, 8'h5A);
      send_segment(31, -3, -32, -3, 1);
      send_segment(7, -32, 7, 31, 128);
      send_segment(-1, 31, -1, -32, 254);
   endtask

   // equal spans stay on the x major axis
   task automatic test_diagonals();
      send_segment(0, 0, 20, 20, 17);
      send_segment(20, 0, 0, 20, 34);
      send_segment(5, 5, -5, -5, 51);
      send_segment(-32, 31, 31, -32, 68);
   endtask

   task automatic test_shallow_and_steep();
      send_segment(-10, 3, 25, -8, 3);
      send_segment(3, -30, -6, 28, 200);
      send_segment(31, 0, -32, 1, 99);
      send_segment(0, 31, 1, -32, 77);
      send_segment(2, 2, 9, 4, 12);
      send_segment(-20, -20, -18, 10, 240);
   endtask

   task automatic test_image_sizes();
      int widths[7] = '{0, 32, 1, 31, 63, 33, 32};
      int heights[7] = '{32, 0, 1, 31, 63, 17, 32};
      for (int i = 0; i < 7; i++) begin
         write_register(REG_IMAGE_WIDTH, widths[i]);
         write_register(REG_IMAGE_HEIGHT, heights[i]);
         repeat (3) send_random_segment();
      end
      // writes to indexes past the register list leave the sizes alone
      write_register(REG_SPARE_2, $urandom_range(63));
      write_register(REG_SPARE_3, $urandom_range(63));
      write_register(REG_SPARE_2, 0);
      write_register(REG_SPARE_3, 63);
      repeat (7) send_random_segment();
   endtask

   task automatic test_random_no_stall();
      drain_lines();
      stall_free = 1'b1;
      repeat (50) send_random_segment();
      drain_lines();
      stall_free = 1'b0;
   endtask

   task automatic test_pause_until_drained();
      repeat (12) begin
         send_random_segment();
         drain_lines();
      end
   endtask

   task automatic test_random_sweep();
      for (int batch = 0; batch < 9; batch++) begin
         write_register(REG_IMAGE_WIDTH, (batch % 3 == 0) ? 32 : $urandom_range(63));
         write_register(REG_IMAGE_HEIGHT, (batch % 4 == 1) ? 32 : $urandom_range(63));
         repeat (30) send_random_segment();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_single_points();
      test_axis_lines();
      test_diagonals();
      test_shallow_and_steep();
      test_image_sizes();
      test_random_no_stall();
      test_pause_until_drained();
      test_random_sweep();
      drain_lines();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
